// File: hw/rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 21;
  localparam int unsigned BufDepth = 4;
  localparam int unsigned CntW     = 3;

  localparam logic [CpW-1:0]   ReplCp   = 21'h00FFFD;
  localparam logic [CpW-1:0]   MaxCp    = 21'h10FFFF;
  localparam logic [ByteW-1:0] AsciiMax = 8'h7F;

  localparam logic [ByteW-1:0] Mask2 = 8'hE0;
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Mask3 = 8'hF0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Mask4 = 8'hF8;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [1:0]       ContTag = 2'b10;

  localparam logic [CntW-1:0] LenInvalid = 3'd0;
  localparam logic [CntW-1:0] LenOne     = 3'd1;
  localparam logic [CntW-1:0] LenTwo     = 3'd2;
  localparam logic [CntW-1:0] LenThree   = 3'd3;
  localparam logic [CntW-1:0] LenFour    = 3'd4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [BufDepth-1:0][ByteW-1:0] buf_t;

  typedef struct packed {
    logic            emit;
    logic            rep;
    logic [CpW-1:0]  cp;
    logic [CntW-1:0] consume;
  } step_t;

  typedef struct packed {
    logic accept;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic can_emit;
    logic slot_free;
    logic last;
  } status_t;

  function automatic logic [CntW-1:0] seq_len(byte_t b);
    logic [CntW-1:0] len;
    if (b <= AsciiMax) begin
      len = LenOne;
    end else if ((b & Mask2) == Lead2) begin
      len = LenTwo;
    end else if ((b & Mask3) == Lead3) begin
      len = LenThree;
    end else if ((b & Mask4) == Lead4) begin
      len = LenFour;
    end else begin
      len = LenInvalid;
    end
    return len;
  endfunction

  function automatic step_t eval_step(buf_t b, logic [CntW-1:0] cnt, logic eot);
    step_t           s;
    logic [CntW-1:0] need;
    logic            bad;
    logic [CpW-1:0]  cp;
    s    = '0;
    need = seq_len(b[0]);
    bad  = 1'b0;
    for (int j = 1; j < BufDepth; j++) begin
      if ((CntW'(j) < need) && (CntW'(j) < cnt) && (b[j][7:6] != ContTag)) begin
        bad = 1'b1;
      end
    end
    case (need)
      LenTwo:   cp = {10'b0, b[0][4:0], b[1][5:0]};
      LenThree: cp = {5'b0, b[0][3:0], b[1][5:0], b[2][5:0]};
      LenFour:  cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      default:  cp = {13'b0, b[0]};
    endcase
    if (need == LenOne) begin
      s.emit    = 1'b1;
      s.cp      = cp;
      s.consume = LenOne;
    end else if ((need == LenInvalid) || bad) begin
      s.emit    = 1'b1;
      s.rep     = 1'b1;
      s.cp      = ReplCp;
      s.consume = LenOne;
    end else if (cnt < need) begin
      if (eot) begin
        s.emit    = 1'b1;
        s.rep     = 1'b1;
        s.cp      = ReplCp;
        s.consume = LenOne;
      end
    end else if (cp > MaxCp) begin
      s.emit    = 1'b1;
      s.rep     = 1'b1;
      s.cp      = ReplCp;
      s.consume = LenOne;
    end else begin
      s.emit    = 1'b1;
      s.cp      = cp;
      s.consume = need;
    end
    return s;
  endfunction

  function automatic buf_t shift_buf(buf_t b, logic [CntW-1:0] n);
    buf_t            r;
    logic [CntW-1:0] idx;
    for (int i = 0; i < BufDepth; i++) begin
      idx = CntW'(i) + n;
      if (idx < LenFour) begin
        r[i] = b[idx[1:0]];
      end else begin
        r[i] = b[i];
      end
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/u8dec_in_if.sv
interface u8dec_in_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::ByteW-1:0] data_byte;
  logic                        end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// File: hw/rtl/u8dec_out_if.sv
interface u8dec_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8dec_pkg::CpW-1:0] cp_value;
  logic                      replaced;
  logic                      last_of_run;
  logic                      text_done;

  modport source (output valid, output cp_value, output replaced, output last_of_run,
                  output text_done, input ready);
  modport sink (input valid, input cp_value, input replaced, input last_of_run,
                input text_done, output ready);
endinterface

// File: hw/rtl/u8dec_datapath.sv
module u8dec_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8dec_pkg::cmd_t               cmd,
  output u8dec_pkg::status_t            status,
  input  logic [u8dec_pkg::ByteW-1:0]   in_data_byte,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u8dec_pkg::CpW-1:0]     out_cp_value,
  output logic                          out_replaced,
  output logic                          out_last_of_run,
  output logic                          out_text_done
);

  u8dec_pkg::buf_t                  buf_r, buf_nxt;
  logic [u8dec_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  logic                             eot_r, eot_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [u8dec_pkg::CpW-1:0]        out_cp_r;
  logic                             out_rep_r;
  logic                             out_last_r;
  logic                             out_done_r;

  u8dec_pkg::step_t                 step;
  u8dec_pkg::step_t                 next_step;
  u8dec_pkg::buf_t                  rest_buf;
  logic [u8dec_pkg::CntW-1:0]       rest_cnt;
  logic                             last;

  always_comb begin
    step      = u8dec_pkg::eval_step(buf_r, cnt_r, eot_r);
    rest_cnt  = cnt_r - step.consume;
    rest_buf  = u8dec_pkg::shift_buf(buf_r, step.consume);
    next_step = u8dec_pkg::eval_step(rest_buf, rest_cnt, eot_r);
    last      = (rest_cnt == '0) || !next_step.emit;
  end

  assign status.can_emit  = step.emit;
  assign status.slot_free = !out_valid_r || out_ready;
  assign status.last      = last;

  always_comb begin
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    eot_nxt       = eot_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.accept) begin
      buf_nxt[cnt_r[1:0]] = in_data_byte;
      cnt_nxt             = cnt_r + 1'b1;
      eot_nxt             = in_end_of_text;
    end
    if (cmd.emit) begin
      buf_nxt       = rest_buf;
      cnt_nxt       = rest_cnt;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    eot_r <= eot_nxt;
    if (cmd.emit) begin
      out_cp_r   <= step.cp;
      out_rep_r  <= step.rep;
      out_last_r <= last;
      out_done_r <= last && eot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cp_value    = out_cp_r;
  assign out_replaced    = out_rep_r;
  assign out_last_of_run = out_last_r;
  assign out_text_done   = out_done_r;

  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> (cnt_r < u8dec_pkg::LenFour))
    else $error("byte taken with a full buffer");

  a_done_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && last && eot_r) |=> (cnt_r == '0))
    else $error("bytes left over after the end of the text");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !last) |=> (cnt_r != '0))
    else $error("result not marked last but the buffer ran empty");

endmodule

// File: hw/rtl/u8dec_ctrl.sv
module u8dec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u8dec_pkg::status_t  status,
  output u8dec_pkg::cmd_t     cmd
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.emit   = (state_r == S_SCAN) && status.can_emit && status.slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!status.can_emit) begin
          state_nxt = S_IDLE;
        end else if (status.slot_free && status.last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (status.slot_free && status.can_emit))
    else $error("result loaded into an occupied output register");

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_SCAN))
    else $error("accepted byte was not scanned");

  a_wait_returns: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !status.can_emit) |=> (state_r == S_IDLE))
    else $error("waiting prefix did not release the input");

endmodule

// File: hw/rtl/utf8_stream_decoder_core.sv
// Channel  Direction  Contents
// in_ch    sink       data_byte[7:0], end_of_text
// out_ch   source     cp_value[20:0], replaced, last_of_run, text_done
//
// A byte is taken when idle, then the scan step gives one result per cycle unless stalled.
// The input stays busy for a byte until its last result is loaded or it waits for more.
// The scan step decodes from a four-byte buffer; a second decode looks ahead to mark the last.
// Reset is synchronous and active low; it empties the buffer and the output register.
// A low out_ch.ready holds the scan; a new byte can be taken while a result waits.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);

  u8dec_pkg::cmd_t    cmd;
  u8dec_pkg::status_t status;

  u8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  u8dec_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_data_byte    (in_ch.data_byte),
    .in_end_of_text  (in_ch.end_of_text),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cp_value    (out_ch.cp_value),
    .out_replaced    (out_ch.replaced),
    .out_last_of_run (out_ch.last_of_run),
    .out_text_done   (out_ch.text_done)
  );

endmodule

// File: test/tb_utf8_stream_decoder_core.sv
module tb_utf8_stream_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TotalItems = 430;
  localparam int unsigned PauseAt    = 200;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 30;

  typedef struct packed {
    logic [u8dec_pkg::CpW-1:0] cp_value;
    logic                      replaced;
    logic                      last_of_run;
    logic                      text_done;
  } cp_item_t;

  class codepoint_board;
    u8dec_pkg::byte_t held[3];
    int unsigned      held_cnt;
    cp_item_t         expected_cps[$];
    int unsigned      errors;
    int unsigned      bytes_in;
    int unsigned      checked;
    int unsigned      repl_seen;
    int unsigned      texts;

    function new();
      foreach (held[i]) held[i] = '0;
      held_cnt  = 0;
      errors    = 0;
      bytes_in  = 0;
      checked   = 0;
      repl_seen = 0;
      texts     = 0;
    endfunction

    function int unsigned lead_len(u8dec_pkg::byte_t b);
      if (b <= u8dec_pkg::AsciiMax) return 1;
      if ((b & u8dec_pkg::Mask2) == u8dec_pkg::Lead2) return 2;
      if ((b & u8dec_pkg::Mask3) == u8dec_pkg::Lead3) return 3;
      if ((b & u8dec_pkg::Mask4) == u8dec_pkg::Lead4) return 4;
      return 0;
    endfunction

    function void push_cp(logic [u8dec_pkg::CpW-1:0] cp, logic rep);
      cp_item_t r;
      r.cp_value    = cp;
      r.replaced    = rep;
      r.last_of_run = 1'b0;
      r.text_done   = 1'b0;
      expected_cps.push_back(r);
    endfunction

    // Decodes the held bytes plus the new one, rescanning after each
    // replacement, and queues every code point this byte releases.
    function void take_byte(u8dec_pkg::byte_t b, logic eot);
      u8dec_pkg::byte_t          win[4];
      int unsigned               n;
      int unsigned               pos;
      int unsigned               avail;
      int unsigned               need;
      int unsigned               start;
      int unsigned               j;
      logic                      bad;
      logic                      stalled;
      logic [u8dec_pkg::CpW-1:0] cp;
      for (j = 0; j < 3; j++) win[j] = held[j];
      win[3]   = '0;
      n        = held_cnt;
      win[n]   = b;
      n++;
      pos      = 0;
      stalled  = 1'b0;
      start    = expected_cps.size();
      bytes_in++;
      while (pos < n && !stalled) begin
        need  = lead_len(win[pos]);
        avail = n - pos;
        bad   = 1'b0;
        for (j = 1; j < need && j < avail; j++) begin
          if (win[pos+j][7:6] != u8dec_pkg::ContTag) bad = 1'b1;
        end
        if (need == 1) begin
          push_cp({13'b0, win[pos]}, 1'b0);
          pos++;
        end else if (need == 0 || bad) begin
          push_cp(u8dec_pkg::ReplCp, 1'b1);
          pos++;
        end else if (avail < need) begin
          if (eot) begin
            push_cp(u8dec_pkg::ReplCp, 1'b1);
            pos++;
          end else begin
            stalled = 1'b1;
          end
        end else begin
          case (need)
            2: cp = {10'b0, win[pos][4:0], win[pos+1][5:0]};
            3: cp = {5'b0, win[pos][3:0], win[pos+1][5:0], win[pos+2][5:0]};
            default: cp = {win[pos][2:0], win[pos+1][5:0], win[pos+2][5:0], win[pos+3][5:0]};
          endcase
          if (cp > u8dec_pkg::MaxCp) begin
            push_cp(u8dec_pkg::ReplCp, 1'b1);
            pos++;
          end else begin
            push_cp(cp, 1'b0);
            pos += need;
          end
        end
      end
      held_cnt = n - pos;
      for (j = 0; j < 3; j++) held[j] = (j < held_cnt) ? win[pos+j] : '0;
      if (expected_cps.size() > start) begin
        expected_cps[expected_cps.size()-1].last_of_run = 1'b1;
        expected_cps[expected_cps.size()-1].text_done   = eot;
      end
      if (eot) texts++;
    endfunction

    function void match_result(cp_item_t got);
      cp_item_t want;
      if (expected_cps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual cp=%h rep=%b last=%b done=%b",
                 $time, got.cp_value, got.replaced, got.last_of_run, got.text_done);
        return;
      end
      want = expected_cps.pop_front();
      checked++;
      if (want.replaced) repl_seen++;
      if (got.cp_value !== want.cp_value) begin
        errors++;
        $display("%0t: cp_value expected %h actual %h", $time,
                 want.cp_value, got.cp_value);
      end
      if (got.replaced !== want.replaced) begin
        errors++;
        $display("%0t: replaced expected %b actual %b", $time, want.replaced, got.replaced);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run expected %b actual %b", $time,
                 want.last_of_run, got.last_of_run);
      end
      if (got.text_done !== want.text_done) begin
        errors++;
        $display("%0t: text_done expected %b actual %b", $time, want.text_done, got.text_done);
      end
    endfunction

    function int unsigned outstanding();
      return expected_cps.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u8dec_in_if  in_ch ();
  u8dec_out_if out_ch ();

  utf8_stream_decoder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  codepoint_board sb = new();
  logic           no_idle = 1'b0;
  int unsigned    sent = 0;
  int unsigned    rx_hold = 0;

  // Directed bytes as {end_of_text, data_byte}.
  logic [8:0] directed_bytes [24] = '{
    9'h000, 9'h17F,
    9'h0DF, 9'h0BF,
    9'h0EF, 9'h0BF, 9'h0BF,
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
    9'h0F4, 9'h090, 9'h080, 9'h080,
    9'h080, 9'h0FF, 9'h0F8,
    9'h0C3, 9'h041,
    9'h0C0, 9'h080,
    9'h0E2, 9'h182
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input u8dec_pkg::byte_t b, input logic eot);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_byte(b, eot);
    sent++;
  endtask

  task automatic send_seq(input u8dec_pkg::byte_t seq[$], input logic eot_last);
    foreach (seq[i]) send_byte(seq[i], eot_last && (i == seq.size() - 1));
  endtask

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      sb.match_result({out_ch.cp_value, out_ch.replaced, out_ch.last_of_run,
                       out_ch.text_done});
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      rx_hold = pick_gap();
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("%0t: no item moved for %0d cycles, %0d results still expected",
             $time, IdleLimit, sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    u8dec_pkg::byte_t          seq[$];
    int unsigned               pick;
    int unsigned               len;
    logic [u8dec_pkg::CpW-1:0] cp;
    logic                      eot;
    logic                      paused;
    paused = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i][7:0], directed_bytes[i][8]);

    while (sent < TotalItems) begin
      seq.delete();
      no_idle = (sent >= 100 && sent < 160);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 4);
        case (len)
          1: begin
            cp = u8dec_pkg::CpW'($urandom_range(0, 'h7F));
            seq.push_back(cp[7:0]);
          end
          2: begin
            cp = u8dec_pkg::CpW'($urandom_range(0, 'h7FF));
            seq.push_back({3'b110, cp[10:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
          3: begin
            cp = u8dec_pkg::CpW'($urandom_range(0, 'hFFFF));
            seq.push_back({4'b1110, cp[15:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
          default: begin
            cp = u8dec_pkg::CpW'(($urandom_range(0, 9) == 0)
                                 ? $urandom_range('h110000, 'h1FFFFF)
                                 : $urandom_range(0, 'h10FFFF));
            seq.push_back({5'b11110, cp[20:18]});
            seq.push_back({2'b10, cp[17:12]});
            seq.push_back({2'b10, cp[11:6]});
            seq.push_back({2'b10, cp[5:0]});
          end
        endcase
        eot = ($urandom_range(0, 9) == 0);
      end else if (pick < 85) begin
        len = $urandom_range(2, 4);
        case (len)
          2: seq.push_back(u8dec_pkg::byte_t'(u8dec_pkg::Lead2 | $urandom_range(0, 31)));
          3: seq.push_back(u8dec_pkg::byte_t'(u8dec_pkg::Lead3 | $urandom_range(0, 15)));
          default: seq.push_back(u8dec_pkg::byte_t'(u8dec_pkg::Lead4 | $urandom_range(0, 7)));
        endcase
        repeat ($urandom_range(0, len - 2))
          seq.push_back(u8dec_pkg::byte_t'(8'h80 | $urandom_range(0, 63)));
        if ($urandom_range(0, 1)) seq.push_back(u8dec_pkg::byte_t'($urandom_range(0, 255)));
        eot = 1'($urandom_range(0, 1));
      end else begin
        seq.push_back(u8dec_pkg::byte_t'($urandom_range(0, 255)));
        eot = ($urandom_range(0, 9) == 0);
      end
      send_seq(seq, eot);
      if (!paused && sent >= PauseAt) begin
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d complete texts; checked %0d code points, %0d replacements.",
             sb.bytes_in, sb.texts, sb.checked, sb.repl_seen);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.outstanding());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
